>>> rtl/nv21_nearest_downscaler_defines.svh
// ----------------------------------------------------------------------------
// NV21 downscaler assertion macros
// Shared property forms for the checker of the NV21 nearest-neighbor
// downscaler.
// ----------------------------------------------------------------------------
`ifndef NV21_NEAREST_DOWNSCALER_DEFINES_SVH
`define NV21_NEAREST_DOWNSCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NVDS_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NVDS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/nvds_pkg.sv
// ----------------------------------------------------------------------------
// NV21 downscaler package
// Shared types, register indexes, reset values and the size clamp used by the
// NV21 nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nvds_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    localparam int unsigned CFG_W           = 13;
    localparam int unsigned CFG_IDX_W       = 4;
    localparam int unsigned BYTE_W          = 8;

    localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = 13'd1080;
    localparam logic [CFG_W-1:0] DST_WIDTH_RST  = 13'd1280;
    localparam logic [CFG_W-1:0] DST_HEIGHT_RST = 13'd720;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 4'd0,
        REG_SRC_HEIGHT = 4'd1,
        REG_DST_WIDTH  = 4'd2,
        REG_DST_HEIGHT = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_is_chroma;
        logic              last_of_frame;
    } t_result;

    // Clamps a programmed size to [2, max_dim] and forces it even.
    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned max_dim);
        int unsigned x;
        x = 32'(v);
        if (x < 32'd2) begin
            x = 32'd2;
        end
        if (x > max_dim) begin
            x = max_dim;
        end
        return x & ~32'd1;
    endfunction

endpackage

>>> rtl/nvds_select.sv
// ----------------------------------------------------------------------------
// NV21 downscaler position tracker
// Tracks the source position and the decimation accumulators, and decides
// combinationally whether the incoming byte is kept.
// ----------------------------------------------------------------------------
module nvds_select #(
    parameter int unsigned MAX_DIM = nvds_pkg::MAX_DIM_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_clear,
    input  logic [nvds_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_frame_start,
    input  nvds_pkg::t_cfg              i_cfg,
    output logic                        o_hit,
    output nvds_pkg::t_result           o_res
);

    localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
    localparam int unsigned PROD_W = 2 * DIM_W;

    logic [DIM_W-1:0]  sw, sh, dw, dh, dw_raw, dh_raw;
    logic [DIM_W-1:0]  col_limit, row_limit, src_rows;

    logic              r_chroma, r_pp;
    logic [DIM_W-1:0]  r_sc, r_sr, r_dc, r_dr;
    logic [PROD_W-1:0] r_cp, r_rp, r_cb, r_rb;

    logic              c_chroma, c_pp;
    logic [DIM_W-1:0]  c_sc, c_sr, c_dc, c_dr;
    logic [PROD_W-1:0] c_cp, c_rp, c_cb, c_rb;

    logic              n_chroma, n_pp;
    logic [DIM_W-1:0]  n_sc, n_sr, n_dc, n_dr;
    logic [PROD_W-1:0] n_cp, n_rp, n_cb, n_rb;

    logic              col_sel, row_sel, pair_done, end_row, end_plane, last;

    always_comb begin
        sw     = DIM_W'(nvds_pkg::eff_size(i_cfg.src_width, MAX_DIM));
        sh     = DIM_W'(nvds_pkg::eff_size(i_cfg.src_height, MAX_DIM));
        dw_raw = DIM_W'(nvds_pkg::eff_size(i_cfg.dst_width, MAX_DIM));
        dh_raw = DIM_W'(nvds_pkg::eff_size(i_cfg.dst_height, MAX_DIM));
        dw     = (dw_raw > sw) ? sw : dw_raw;
        dh     = (dh_raw > sh) ? sh : dh_raw;
    end

    // A frame start byte sees the cleared position.
    always_comb begin
        c_chroma = i_frame_start ? 1'b0 : r_chroma;
        c_pp     = i_frame_start ? 1'b0 : r_pp;
        c_sc     = i_frame_start ? '0 : r_sc;
        c_sr     = i_frame_start ? '0 : r_sr;
        c_dc     = i_frame_start ? '0 : r_dc;
        c_dr     = i_frame_start ? '0 : r_dr;
        c_cp     = i_frame_start ? '0 : r_cp;
        c_rp     = i_frame_start ? '0 : r_rp;
        c_cb     = i_frame_start ? '0 : r_cb;
        c_rb     = i_frame_start ? '0 : r_rb;
    end

    // The column and row bases hold unit * dst size, so a kept position is one
    // whose product lies below base + dst size.
    always_comb begin
        col_limit = c_chroma ? (dw >> 1) : dw;
        row_limit = c_chroma ? (dh >> 1) : dh;
        src_rows  = c_chroma ? (sh >> 1) : sh;
        col_sel   = (c_dc < col_limit) && (c_cp < (c_cb + PROD_W'(dw)));
        row_sel   = (c_dr < row_limit) && (c_rp < (c_rb + PROD_W'(dh)));
        last      = c_chroma && c_pp && (c_dr == row_limit - 1'b1)
                    && (c_dc == col_limit - 1'b1);
        pair_done = !c_chroma || c_pp;
        end_row   = ({1'b0, c_sc} + 1'b1) >= {1'b0, sw};
        end_plane = ({1'b0, c_sr} + 1'b1) >= {1'b0, src_rows};
    end

    always_comb begin
        n_chroma = c_chroma;
        n_pp     = c_chroma ? ~c_pp : c_pp;
        n_sc     = c_sc + 1'b1;
        n_sr     = c_sr;
        n_dc     = c_dc;
        n_dr     = c_dr;
        n_cp     = c_cp;
        n_rp     = c_rp;
        n_cb     = c_cb;
        n_rb     = c_rb;
        if (pair_done && col_sel) begin
            n_dc = c_dc + 1'b1;
            n_cp = c_cp + PROD_W'(sw);
        end
        if (pair_done) begin
            n_cb = c_cb + PROD_W'(dw);
        end
        if (end_row) begin
            if (row_sel) begin
                n_dr = c_dr + 1'b1;
                n_rp = c_rp + PROD_W'(sh);
            end
            n_sr = c_sr + 1'b1;
            n_rb = c_rb + PROD_W'(dh);
            n_sc = '0;
            n_dc = '0;
            n_cp = '0;
            n_cb = '0;
            n_pp = 1'b0;
            if (end_plane) begin
                n_sr     = '0;
                n_dr     = '0;
                n_rp     = '0;
                n_rb     = '0;
                n_chroma = ~c_chroma;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_chroma <= 1'b0;
            r_pp     <= 1'b0;
            r_sc     <= '0;
            r_sr     <= '0;
            r_dc     <= '0;
            r_dr     <= '0;
            r_cp     <= '0;
            r_rp     <= '0;
            r_cb     <= '0;
            r_rb     <= '0;
        end else if (i_accept) begin
            r_chroma <= n_chroma;
            r_pp     <= n_pp;
            r_sc     <= n_sc;
            r_sr     <= n_sr;
            r_dc     <= n_dc;
            r_dr     <= n_dr;
            r_cp     <= n_cp;
            r_rp     <= n_rp;
            r_cb     <= n_cb;
            r_rb     <= n_rb;
        end
    end

    assign o_hit               = col_sel && row_sel;
    assign o_res.out_byte      = i_in_byte;
    assign o_res.out_is_chroma = c_chroma;
    assign o_res.last_of_frame = last;

endmodule

>>> rtl/nvds_skid.sv
// ----------------------------------------------------------------------------
// NV21 downscaler output buffer
// Output register with one skid entry, so that the input side stalls only
// from a registered full flag.
// ----------------------------------------------------------------------------
module nvds_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nvds_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output nvds_pkg::t_result o_res,
    output logic              o_full
);

    logic              r_valid, r_skid_valid;
    nvds_pkg::t_result r_res, r_skid;
    logic              n_valid, n_skid_valid;
    nvds_pkg::t_result n_res, n_skid;
    logic              take;

    always_comb begin
        take         = r_valid && !i_stall;
        n_valid      = r_valid;
        n_skid_valid = r_skid_valid;
        n_res        = r_res;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (take) begin
                n_res        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid || take) begin
                n_res   = i_res;
                n_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_skid <= n_skid;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_full  = r_skid_valid;

endmodule

>>> rtl/nv21_nearest_downscaler.sv
// ----------------------------------------------------------------------------
// NV21 nearest-neighbor downscaler
// Takes an NV21 frame one byte per request, luma plane then VU plane, and
// passes on the bytes that nearest-neighbor decimation keeps.
//
//   Channel   Direction   Handshake                 Payload
//   in        input       i_in_valid / o_in_stall   i_in_byte, i_frame_start
//   out       output      o_out_valid / i_out_stall o_out_byte, o_out_is_chroma,
//                                                   o_last_of_frame
//   cfg       input       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One request is taken per cycle while the input is not stalled; a kept byte
// is registered in the output register, or in the skid entry while that is held.
// Reset is synchronous and active low and restores the default sizes.
// Input stalls only when the output register and its skid entry are both full.
// Any size write restarts the frame position.
// ----------------------------------------------------------------------------
module nv21_nearest_downscaler #(
    parameter int unsigned MAX_DIM = nvds_pkg::MAX_DIM_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [nvds_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                           i_frame_start,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [nvds_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_out_is_chroma,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_we,
    input  logic [nvds_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nvds_pkg::CFG_W-1:0]     i_cfg_data
);

    nvds_pkg::t_cfg    r_cfg;
    nvds_pkg::t_result sel_res, out_res;
    logic              cfg_hit, accept, hit, full;

    always_comb begin
        cfg_hit = 1'b0;
        case (i_cfg_index)
            nvds_pkg::REG_SRC_WIDTH:  cfg_hit = i_cfg_we;
            nvds_pkg::REG_SRC_HEIGHT: cfg_hit = i_cfg_we;
            nvds_pkg::REG_DST_WIDTH:  cfg_hit = i_cfg_we;
            nvds_pkg::REG_DST_HEIGHT: cfg_hit = i_cfg_we;
            default:                  cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= nvds_pkg::SRC_WIDTH_RST;
            r_cfg.src_height <= nvds_pkg::SRC_HEIGHT_RST;
            r_cfg.dst_width  <= nvds_pkg::DST_WIDTH_RST;
            r_cfg.dst_height <= nvds_pkg::DST_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nvds_pkg::REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data;
                nvds_pkg::REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data;
                nvds_pkg::REG_DST_WIDTH:  r_cfg.dst_width  <= i_cfg_data;
                nvds_pkg::REG_DST_HEIGHT: r_cfg.dst_height <= i_cfg_data;
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    assign accept = i_in_valid && !full;

    nvds_select #(
        .MAX_DIM (MAX_DIM)
    ) u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_clear       (cfg_hit),
        .i_in_byte     (i_in_byte),
        .i_frame_start (i_frame_start),
        .i_cfg         (r_cfg),
        .o_hit         (hit),
        .o_res         (sel_res)
    );

    nvds_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && hit),
        .i_res   (sel_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    assign o_in_stall      = full;
    assign o_out_byte      = out_res.out_byte;
    assign o_out_is_chroma = out_res.out_is_chroma;
    assign o_last_of_frame = out_res.last_of_frame;

endmodule

>>> rtl/nvds_checker.sv
// ----------------------------------------------------------------------------
// NV21 downscaler checker
// Port-level assertions for the NV21 nearest-neighbor downscaler, bound to
// the top level.
// ----------------------------------------------------------------------------
`include "nv21_nearest_downscaler_defines.svh"

module nvds_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [nvds_pkg::BYTE_W-1:0]    o_out_byte,
    input logic                           o_out_is_chroma,
    input logic                           o_last_of_frame
);

    `NVDS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_stall, "output not empty after reset")
    `NVDS_ASSERT_SAME(a_last_chroma, i_clk, !i_rst_n, o_out_valid && o_last_of_frame, o_out_is_chroma, "frame end on a luma byte")
    `NVDS_ASSERT_SAME(a_stall_full, i_clk, !i_rst_n, o_in_stall, o_out_valid, "input stalled with empty output")
    `NVDS_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_byte) && $stable(o_out_is_chroma) && $stable(o_last_of_frame), "stalled request changed")

endmodule

bind nv21_nearest_downscaler nvds_checker u_checker (.*);
